// ===== hw/rtl/pas_pkg.sv =====
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types, codes and priority helpers for the priority aging scheduler.
// ----------------------------------------------------------------------------
package pas_pkg;

    // Slot table geometry
    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int REQ_W    = 8;
    localparam int PRIO_W   = 6;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef logic signed [REQ_W-1:0]  req_prio_t;
    typedef logic [STAMP_W-1:0]       stamp_t;

    // Priority window
    localparam prio_t PRIO_MIN = -6'sd20;
    localparam prio_t PRIO_MAX = 6'sd20;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_PRIO = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IN_USE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

    // Word stored in the priority memory
    typedef struct packed {
        prio_t dyn;
        prio_t stat;
    } prio_word_t;

    // One slot as seen by the compare unit
    typedef struct packed {
        prio_t  dyn;
        prio_t  stat;
        stamp_t stamp;
    } entry_t;

    localparam int PRIO_WORD_W = $bits(prio_word_t);

    // Clamp a requested priority into the window
    function automatic prio_t clamp_req(input req_prio_t p);
        prio_t r;
        if (p < -8'sd20) begin
            r = PRIO_MIN;
        end else if (p > 8'sd20) begin
            r = PRIO_MAX;
        end else begin
            r = p[PRIO_W-1:0];
        end
        return r;
    endfunction

    // Clamp an aged sum (one bit wider than a priority) into the window
    function automatic prio_t clamp_sum(input logic signed [PRIO_W:0] s);
        prio_t r;
        if (s < -7'sd20) begin
            r = PRIO_MIN;
        end else if (s > 7'sd20) begin
            r = PRIO_MAX;
        end else begin
            r = s[PRIO_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pas_ram.sv =====
// ----------------------------------------------------------------------------
// pas_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pas_eval.sv =====
// ----------------------------------------------------------------------------
// pas_eval
// Shared compare and aging unit: decides whether a candidate slot beats the
// current best and forms its aged dynamic priority.
// ----------------------------------------------------------------------------
module pas_eval (
    input  pas_pkg::entry_t cand,
    input  pas_pkg::entry_t best,
    input  logic            best_found,
    input  pas_pkg::prio_t  aging_step,
    output logic            take,
    output pas_pkg::prio_t  aged
);
    import pas_pkg::*;

    logic                    beats;
    logic signed [PRIO_W:0]  sum;

    // lower dynamic, then lower static, then earlier arrival
    always_comb begin
        if (cand.dyn != best.dyn) begin
            beats = cand.dyn < best.dyn;
        end else if (cand.stat != best.stat) begin
            beats = cand.stat < best.stat;
        end else begin
            beats = cand.stamp < best.stamp;
        end
    end

    assign take = !best_found || beats;

    // aging add, kept inside the priority window
    assign sum  = {cand.dyn[PRIO_W-1], cand.dyn} + {aging_step[PRIO_W-1], aging_step};
    assign aged = clamp_sum(sum);

endmodule

// ===== hw/rtl/priority_aging_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_aging_scheduler
// Task slot table with insert, remove, set-priority and aging schedule.
// ----------------------------------------------------------------------------
// Flow: every accepted word yields one result word. Insert, remove and
// set-priority go from the idle state straight to the result state, which
// loads the output register and returns to idle. The slot memories have
// one read port, so a schedule scan visits one slot per cycle through the
// shared compare and aging unit, writing each aged priority back behind the
// read. The registered read puts each compare behind its read, and the scan
// ends once the compare stage has drained. The fix state then restores the
// winner's priority and the result state loads the output register. s_tready
// is low while a word is in work. A finished result waits in the output
// register without holding off the next input word; that word's result then
// waits until the output register is free, and s_tready stays low meanwhile.
// Slot memories need no clearing after reset, since only slots marked ready
// are ever compared or aged.
// ----------------------------------------------------------------------------
module priority_aging_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] slot, [11:4] prio, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] picked_slot, [7:4] zero
    output logic [2:0]  m_tuser,   // [0] picked_valid, [2:1] status
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // aging_step
);
    import pas_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;
    localparam logic [1:0] ST_RES  = 2'd3;

    // input fields
    logic [FUNC_W-1:0] in_func;
    logic [SLOT_W-1:0] in_slot;
    req_prio_t         in_prio;
    prio_t             in_prio_c;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;

    assign in_func   = s_tuser[FUNC_W-1:0];
    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_prio   = s_tdata[SLOT_W+REQ_W-1:SLOT_W];
    assign in_prio_c = clamp_req(in_prio);
    assign in_idx    = IDX_W'(in_slot);
    assign in_range  = int'(in_slot) < NUM_SLOTS;

    // control state
    logic [1:0]           state_reg, state_next;
    logic [NUM_SLOTS-1:0] ready_reg, ready_next;
    stamp_t               arr_cnt_reg, arr_cnt_next;
    prio_t                step_reg, step_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic                 found_reg, found_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // payload
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    entry_t               best_reg, best_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 res_valid_reg, res_valid_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic [2:0]           m_tuser_reg, m_tuser_next;

    // memory ports
    logic                 pw_en;
    logic [IDX_W-1:0]     pw_addr;
    prio_word_t           pw_data;
    logic [PRIO_WORD_W-1:0] pr_data;
    logic                 sw_en;
    stamp_t               sr_data;
    logic [IDX_W-1:0]     rd_addr;

    // compare unit
    entry_t               cand;
    prio_word_t           pr_word;
    logic                 take;
    prio_t                aged;

    assign rd_addr = cnt_reg[IDX_W-1:0];

    pas_ram #(
        .WIDTH(PRIO_WORD_W),
        .DEPTH(NUM_SLOTS)
    ) u_prio_ram (
        .aclk (aclk),
        .we   (pw_en),
        .waddr(pw_addr),
        .wdata(pw_data),
        .raddr(rd_addr),
        .rdata(pr_data)
    );

    pas_ram #(
        .WIDTH(STAMP_W),
        .DEPTH(NUM_SLOTS)
    ) u_stamp_ram (
        .aclk (aclk),
        .we   (sw_en),
        .waddr(in_idx),
        .wdata(arr_cnt_reg),
        .raddr(rd_addr),
        .rdata(sr_data)
    );

    assign pr_word    = prio_word_t'(pr_data);
    assign cand.dyn   = pr_word.dyn;
    assign cand.stat  = pr_word.stat;
    assign cand.stamp = sr_data;

    pas_eval u_eval (
        .cand      (cand),
        .best      (best_reg),
        .best_found(found_reg),
        .aging_step(step_reg),
        .take      (take),
        .aged      (aged)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        ready_next      = ready_reg;
        arr_cnt_next    = arr_cnt_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        res_valid_next  = res_valid_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        pw_en           = 1'b0;
        pw_addr         = in_idx;
        pw_data         = '{dyn: in_prio_c, stat: in_prio_c};
        sw_en           = 1'b0;

        // register write
        if (cfg_valid) begin
            step_next = cfg_data;
        end

        // output word taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_valid_next  = 1'b0;
                    res_slot_next   = '0;
                    res_status_next = STAT_OK;
                    if (in_func == FUNC_SCHEDULE) begin
                        cnt_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RES;
                        if (!in_range) begin
                            res_status_next = STAT_EMPTY;
                        end else if (in_func == FUNC_INSERT) begin
                            if (ready_reg[in_idx]) begin
                                res_status_next = STAT_IN_USE;
                            end else begin
                                ready_next[in_idx] = 1'b1;
                                pw_en              = 1'b1;
                                sw_en              = 1'b1;
                                arr_cnt_next       = arr_cnt_reg + 1'b1;
                            end
                        end else if (!ready_reg[in_idx]) begin
                            res_status_next = STAT_EMPTY;
                        end else if (in_func == FUNC_REMOVE) begin
                            ready_next[in_idx] = 1'b0;
                        end else begin
                            pw_en = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue next read
                if (cnt_reg != CNT_W'(NUM_SLOTS)) begin
                    cnt_next     = cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IDX_W-1:0];
                end
                // compare and age the slot read last cycle
                if (cmp_vld_reg && ready_reg[cmp_idx_reg]) begin
                    pw_en   = 1'b1;
                    pw_addr = cmp_idx_reg;
                    pw_data = '{dyn: aged, stat: cand.stat};
                    if (take) begin
                        best_next     = cand;
                        best_idx_next = cmp_idx_reg;
                        found_next    = 1'b1;
                    end
                end
                if (!cmp_vld_reg && cnt_reg == CNT_W'(NUM_SLOTS)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                // winner drops back to its static priority
                if (found_reg) begin
                    pw_en           = 1'b1;
                    pw_addr         = best_idx_reg;
                    pw_data         = '{dyn: best_reg.stat, stat: best_reg.stat};
                    res_valid_next  = 1'b1;
                    res_slot_next   = SLOT_W'(best_idx_reg);
                    res_status_next = STAT_OK;
                end else begin
                    res_valid_next  = 1'b0;
                    res_slot_next   = '0;
                    res_status_next = STAT_NO_READY;
                end
                state_next = ST_RES;
            end
            ST_RES: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, res_slot_reg};
                    m_tuser_next  = {res_status_reg, res_valid_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ready_reg    <= '0;
            arr_cnt_reg  <= '0;
            step_reg     <= -6'sd1;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            arr_cnt_reg  <= arr_cnt_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg    <= cmp_idx_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        res_valid_reg  <= res_valid_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ===== hw/rtl/pas_checker.sv =====
// ----------------------------------------------------------------------------
// pas_checker
// Port-level checks for the priority aging scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pas_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser
);
    import pas_pkg::*;

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // block is not ready in the cycle after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // a pick always reports ok
    a_pick_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STAT_OK)
        else $error("picked word with non-ok status");

    // no pick means slot field is zero
    a_nopick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[3:0] == 4'd0)
        else $error("slot field set without a pick");

endmodule

bind priority_aging_scheduler pas_checker u_pas_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// ===== dv/priority_aging_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// priority_aging_scheduler_tb
// Self-checking bench for the aging priority scheduler. A behavioral copy of
// the slot table predicts every result word at the moment its command word is
// accepted. The checker compares each result field by field, in order. Traffic
// starts with directed corner cases and moves on to constrained random command
// streams under several aging steps, random idling on both sides, one long
// output hold-off and a full pause of the sender.
// ----------------------------------------------------------------------------
module priority_aging_scheduler_tb;
    import pas_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYC  = 25;
    localparam int HOLD_CYC    = 400;
    localparam int MAX_REPORTS = 10;

    // One result word as the scheduler should return it
    typedef struct {
        logic                valid;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [3:0] slot, [11:4] prio, [15:12] zero
    logic [1:0]  s_tuser   = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [3:0] picked_slot, [7:4] zero
    logic [2:0]  m_tuser;          // [0] picked_valid, [2:1] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = '0;   // aging_step

    // Shadow copy of the slot table
    logic          slot_ready [NUM_SLOTS];
    prio_t         slot_stat  [NUM_SLOTS];
    prio_t         slot_dyn   [NUM_SLOTS];
    stamp_t        slot_stamp [NUM_SLOTS];
    stamp_t        next_stamp;
    prio_t         cur_step;

    sched_result_t pending_results [$];
    sched_result_t want;
    int            mismatches    = 0;
    int            cycle_count   = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    logic          hold_active   = 1'b0;
    event          hold_trig;

    priority_aging_scheduler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Long output hold-off, counted here
    always begin
        @(hold_trig);
        hold_active <= 1'b1;
        repeat (HOLD_CYC) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic prio_t clamp_window(input int v);
        if (v < int'(PRIO_MIN)) return PRIO_MIN;
        if (v > int'(PRIO_MAX)) return PRIO_MAX;
        return prio_t'(v);
    endfunction

    // True when slot a takes precedence over slot b
    function automatic logic outranks(input int a, input int b);
        if (slot_dyn[a] != slot_dyn[b]) return slot_dyn[a] < slot_dyn[b];
        if (slot_stat[a] != slot_stat[b]) return slot_stat[a] < slot_stat[b];
        return slot_stamp[a] < slot_stamp[b];
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ready[i] = 1'b0;
            slot_stat[i]  = '0;
            slot_dyn[i]   = '0;
            slot_stamp[i] = '0;
        end
        next_stamp = '0;
        cur_step   = -6'sd1;
    endfunction

    // Apply one command to the table and return the word it should produce
    function automatic sched_result_t apply_op(input logic [FUNC_W-1:0] func,
                                               input logic [SLOT_W-1:0] slot,
                                               input req_prio_t req);
        sched_result_t res;
        prio_t         p;
        int            best;
        res.valid  = 1'b0;
        res.slot   = '0;
        res.status = STAT_OK;
        p    = clamp_window(int'(req));
        best = -1;
        if (func == FUNC_SCHEDULE) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_ready[i] && (best < 0 || outranks(i, best))) best = i;
            end
            if (best < 0) begin
                res.status = STAT_NO_READY;
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!slot_ready[i]) continue;
                    if (i == best) slot_dyn[i] = slot_stat[i];
                    else slot_dyn[i] = clamp_window(int'(slot_dyn[i]) + int'(cur_step));
                end
                res.valid = 1'b1;
                res.slot  = best[SLOT_W-1:0];
            end
        end else if (func == FUNC_INSERT) begin
            if (slot_ready[slot]) begin
                res.status = STAT_IN_USE;
            end else begin
                slot_ready[slot] = 1'b1;
                slot_stat[slot]  = p;
                slot_dyn[slot]   = p;
                slot_stamp[slot] = next_stamp;
                next_stamp       = next_stamp + 1;
            end
        end else if (!slot_ready[slot]) begin
            res.status = STAT_EMPTY;
        end else if (func == FUNC_REMOVE) begin
            slot_ready[slot] = 1'b0;
        end else begin
            slot_stat[slot] = p;
            slot_dyn[slot]  = p;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and output ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result word: valid %b slot %0d status %0d",
                             $realtime, m_tuser[0], m_tdata[3:0], m_tuser[2:1]);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.valid || m_tdata[3:0] !== want.slot ||
                    m_tuser[2:1] !== want.status || m_tdata[7:4] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] result mismatch: exp valid %b slot %0d status %0d,",
                                  " got valid %b slot %0d status %0d pad %h"},
                                 $realtime, want.valid, want.slot, want.status,
                                 m_tuser[0], m_tdata[3:0], m_tuser[2:1], m_tdata[7:4]);
                end
            end
        end
        m_tready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    // Offer one command word and record its expected result on acceptance
    task automatic send_word(input logic [FUNC_W-1:0] func,
                             input logic [SLOT_W-1:0] slot,
                             input req_prio_t prio);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'd0, prio, slot};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_op(func, slot, prio));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Program the aging step; only called with the block idle
    task automatic write_step(input prio_t step);
        cfg_valid <= 1'b1;
        cfg_data  <= step;
        do @(posedge aclk); while (!cfg_ready);
        cur_step = step;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Empty table, clamping, duplicate insert, empty-slot errors, arrival ties
    task automatic test_directed();
        send_word(FUNC_SCHEDULE, 4'd0, 8'sd0);
        send_word(FUNC_REMOVE,   4'd3, 8'sd0);
        send_word(FUNC_SET_PRIO, 4'd3, 8'sd0);
        send_word(FUNC_INSERT,   4'd0, -8'sd128);
        send_word(FUNC_INSERT,   4'd15, 8'sd127);
        send_word(FUNC_INSERT,   4'd0, 8'sd5);
        send_word(FUNC_INSERT,   4'd5, 8'sd0);
        send_word(FUNC_INSERT,   4'd6, -8'sd21);
        send_word(FUNC_INSERT,   4'd7, 8'sd21);
        // same dynamic and static priority: earliest arrival wins
        send_word(FUNC_SET_PRIO, 4'd5, -8'sd20);
        repeat (4) send_word(FUNC_SCHEDULE, 4'd15, 8'sd0);
        send_word(FUNC_REMOVE,   4'd0, 8'sd0);
        send_word(FUNC_REMOVE,   4'd0, 8'sd0);
        send_word(FUNC_SET_PRIO, 4'd15, 8'sh55);
        send_word(FUNC_SET_PRIO, 4'd7, -8'sh56);
        send_word(FUNC_SCHEDULE, 4'd0, 8'sd0);
        send_word(FUNC_REMOVE,   4'd5, 8'sd0);
        send_word(FUNC_REMOVE,   4'd6, 8'sd0);
        send_word(FUNC_REMOVE,   4'd7, 8'sd0);
        send_word(FUNC_REMOVE,   4'd15, 8'sd0);
        send_word(FUNC_SCHEDULE, 4'd0, 8'sd0);
        drain();
    endtask

    // Steep aging floors everyone at the minimum: static priority breaks ties
    task automatic test_static_tie();
        write_step(-6'sd20);
        send_word(FUNC_INSERT, 4'd1, 8'sd20);
        send_word(FUNC_INSERT, 4'd2, -8'sd20);
        send_word(FUNC_INSERT, 4'd3, 8'sd0);
        repeat (4) send_word(FUNC_SCHEDULE, 4'd0, 8'sd0);
        drain();
    endtask

    // Mostly well-formed command stream with random content
    task automatic run_random(input int count);
        int          ready_slots [$];
        int          free_slots  [$];
        int          r;
        logic [1:0]  func;
        logic [3:0]  slot;
        req_prio_t   prio;
        for (int n = 0; n < count; n++) begin
            ready_slots.delete();
            free_slots.delete();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_ready[i]) ready_slots.push_back(i);
                else free_slots.push_back(i);
            end
            r = $urandom_range(99);
            if (r < 40) func = FUNC_SCHEDULE;
            else if (r < 70) func = FUNC_INSERT;
            else if (r < 85) func = FUNC_REMOVE;
            else func = FUNC_SET_PRIO;
            // keep the table from saturating
            if (func == FUNC_INSERT && ready_slots.size() > 10 && $urandom_range(1))
                func = FUNC_REMOVE;
            slot = 4'($urandom_range(15));
            if ($urandom_range(9) < 8) begin
                if (func == FUNC_INSERT && free_slots.size() != 0)
                    slot = 4'(free_slots[$urandom_range(free_slots.size() - 1)]);
                else if ((func == FUNC_REMOVE || func == FUNC_SET_PRIO) &&
                         ready_slots.size() != 0)
                    slot = 4'(ready_slots[$urandom_range(ready_slots.size() - 1)]);
            end
            if ($urandom_range(3) != 0) prio = 8'(int'($urandom_range(50)) - 25);
            else prio = 8'($urandom_range(255));
            send_word(func, slot, prio);
        end
        drain();
    endtask

    // Random phases over several aging steps, extremes included
    task automatic test_aging_sweep();
        send_idle_pct = 16;
        recv_idle_pct = 74;
        write_step(-6'sd1);
        run_random(200);
        write_step(-6'sd20);
        run_random(200);
        send_idle_pct = 74;
        recv_idle_pct = 16;
        write_step(6'sd0);
        run_random(200);
        // positive step: aged priorities are capped at the top of the window
        write_step(6'sd31);
        run_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step(-6'sd32);
        run_random(200);
        write_step(-6'sd5);
        run_random(200);
    endtask

    // Output stalled for a long stretch while commands keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_trig;
        run_random(40);
    endtask

    // Sender waits for every result between two bursts
    task automatic test_pause();
        send_idle_pct = 30;
        recv_idle_pct = 30;
        run_random(30);
        run_random(30);
    endtask

    initial begin
        clear_table();
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_static_tie();
        test_aging_sweep();
        test_backpressure();
        test_pause();
        drain();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
